// File: sv/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held low.
`define ASSERT_CLK_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// File: sv/mdt_pkg.sv
package mdt_pkg;

    localparam int unsigned MDT_VALUE_BITS      = 47;
    localparam int unsigned MDT_DATE_BITS       = 40;
    localparam int unsigned MDT_RATIO_FRAC_BITS = 16;
    localparam int unsigned MDT_INDEX_BITS      = 32;

    // Status of the result queue between tracker and divider.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } t_back_state;

endpackage

// File: sv/mdt_front.sv
module mdt_front import mdt_pkg::*; #(
    parameter int unsigned VALUE_BITS = MDT_VALUE_BITS,
    parameter int unsigned DATE_BITS  = MDT_DATE_BITS,
    parameter int unsigned INDEX_BITS = MDT_INDEX_BITS,
    localparam int unsigned REC_W     = 1 + 3 * VALUE_BITS + 2 * DATE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [DATE_BITS-1:0]  i_date_stamp,
    input  logic [VALUE_BITS-1:0] i_portfolio_value,
    input  logic                  i_last_item,
    input  t_q_status             i_q_status,
    output logic                  o_q_push,
    output logic [REC_W-1:0]      o_q_wdata
);

    logic [VALUE_BITS-1:0] r_peak_value, n_peak_value;
    logic [DATE_BITS-1:0]  r_peak_date, n_peak_date;
    logic [INDEX_BITS-1:0] r_peak_index, n_peak_index;
    logic [INDEX_BITS-1:0] r_count, n_count;
    logic [VALUE_BITS-1:0] r_best_drop, n_best_drop;
    logic [VALUE_BITS-1:0] r_best_peak, n_best_peak;
    logic [VALUE_BITS-1:0] r_best_trough, n_best_trough;
    logic [DATE_BITS-1:0]  r_best_pdate, n_best_pdate;
    logic [DATE_BITS-1:0]  r_best_tdate, n_best_tdate;
    logic [INDEX_BITS-1:0] r_best_index, n_best_index;
    logic                  r_have, n_have;

    logic                  accept;
    logic                  take_peak;
    logic                  better;
    logic [VALUE_BITS-1:0] drop;

    assign o_in_ready = !i_q_status.full;
    assign accept     = i_in_valid && o_in_ready;

    assign take_peak = (r_count == '0) || (i_portfolio_value >= r_peak_value);
    assign drop      = r_peak_value - i_portfolio_value;
    // Equal drops go to the later peak; a given peak keeps its first trough.
    assign better    = !r_have || (drop > r_best_drop) ||
                       ((drop == r_best_drop) && (r_peak_index > r_best_index));

    always_comb begin
        n_peak_value  = r_peak_value;
        n_peak_date   = r_peak_date;
        n_peak_index  = r_peak_index;
        n_best_drop   = r_best_drop;
        n_best_peak   = r_best_peak;
        n_best_trough = r_best_trough;
        n_best_pdate  = r_best_pdate;
        n_best_tdate  = r_best_tdate;
        n_best_index  = r_best_index;
        n_have        = r_have;
        n_count       = r_count;
        if (accept) begin
            if (take_peak) begin
                n_peak_value = i_portfolio_value;
                n_peak_date  = i_date_stamp;
                n_peak_index = r_count;
            end else if (better) begin
                n_have        = 1'b1;
                n_best_drop   = drop;
                n_best_peak   = r_peak_value;
                n_best_trough = i_portfolio_value;
                n_best_pdate  = r_peak_date;
                n_best_tdate  = i_date_stamp;
                n_best_index  = r_peak_index;
            end
            // Saturate the sample index at its maximum.
            if (r_count != '1) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    assign o_q_push  = accept && i_last_item;
    assign o_q_wdata = {n_have, n_best_drop, n_best_peak, n_best_trough,
                        n_best_pdate, n_best_tdate};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_q_push) begin
            r_peak_value  <= '0;
            r_peak_date   <= '0;
            r_peak_index  <= '0;
            r_count       <= '0;
            r_best_drop   <= '0;
            r_best_peak   <= '0;
            r_best_trough <= '0;
            r_best_pdate  <= '0;
            r_best_tdate  <= '0;
            r_best_index  <= '0;
            r_have        <= 1'b0;
        end else begin
            r_peak_value  <= n_peak_value;
            r_peak_date   <= n_peak_date;
            r_peak_index  <= n_peak_index;
            r_count       <= n_count;
            r_best_drop   <= n_best_drop;
            r_best_peak   <= n_best_peak;
            r_best_trough <= n_best_trough;
            r_best_pdate  <= n_best_pdate;
            r_best_tdate  <= n_best_tdate;
            r_best_index  <= n_best_index;
            r_have        <= n_have;
        end
    end

endmodule

// File: sv/mdt_queue.sv
module mdt_queue import mdt_pkg::*; #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output t_q_status        o_status
);

    // Two-entry queue of finished stream records.
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             do_push;
    logic             do_pop;

    assign o_status = t_q_status'{full: (r_count == 2'd2), empty: (r_count == 2'd0)};
    assign do_push  = i_push && !o_status.full;
    assign do_pop   = i_pop && !o_status.empty;
    assign o_rdata  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: sv/mdt_back.sv
module mdt_back import mdt_pkg::*; #(
    parameter int unsigned VALUE_BITS      = MDT_VALUE_BITS,
    parameter int unsigned DATE_BITS       = MDT_DATE_BITS,
    parameter int unsigned RATIO_FRAC_BITS = MDT_RATIO_FRAC_BITS,
    localparam int unsigned REC_W          = 1 + 3 * VALUE_BITS + 2 * DATE_BITS,
    localparam int unsigned STEP_BITS      = $clog2(RATIO_FRAC_BITS + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_q_status                  i_q_status,
    input  logic [REC_W-1:0]           i_q_rdata,
    output logic                       o_q_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_found_drop,
    output logic [VALUE_BITS-1:0]      o_drop_amount,
    output logic [RATIO_FRAC_BITS:0]   o_drop_ratio,
    output logic [VALUE_BITS-1:0]      o_peak_value_out,
    output logic [VALUE_BITS-1:0]      o_trough_value_out,
    output logic [DATE_BITS-1:0]       o_peak_date_out,
    output logic [DATE_BITS-1:0]       o_trough_date_out
);

    t_back_state r_state, n_state;

    logic                     q_found;
    logic [VALUE_BITS-1:0]    q_drop;
    logic [VALUE_BITS-1:0]    q_peak;
    logic [VALUE_BITS-1:0]    q_trough;
    logic [DATE_BITS-1:0]     q_pdate;
    logic [DATE_BITS-1:0]     q_tdate;

    logic [REC_W-1:0]         r_rec;
    logic [VALUE_BITS:0]      r_rem;
    logic [RATIO_FRAC_BITS:0] r_quo;
    logic [STEP_BITS-1:0]     r_step;
    logic                     r_out_valid;

    logic                     load_rec;
    logic                     do_step;
    logic                     load_out;
    logic                     out_free;
    logic                     last_step;

    logic [VALUE_BITS:0]      rem_in;
    logic                     rem_ge;

    assign {q_found, q_drop, q_peak, q_trough, q_pdate, q_tdate} = r_rec;

    assign out_free  = !r_out_valid || i_out_ready;
    assign last_step = (r_step == STEP_BITS'(RATIO_FRAC_BITS));

    // First step compares the bare numerator, later steps shift in a zero.
    assign rem_in = (r_step == '0) ? r_rem : {r_rem[VALUE_BITS-1:0], 1'b0};
    assign rem_ge = rem_in >= {1'b0, q_peak};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_status.empty) begin
                    n_state = i_q_rdata[REC_W-1] ? BK_DIV : BK_DONE;
                end
            end
            BK_DIV: begin
                if (last_step) begin
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        load_rec = 1'b0;
        do_step  = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            BK_IDLE: load_rec = !i_q_status.empty;
            BK_DIV:  do_step  = 1'b1;
            BK_DONE: load_out = out_free;
            default: begin
                load_rec = 1'b0;
            end
        endcase
    end

    assign o_q_pop = load_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_rec) begin
            r_rec  <= i_q_rdata;
            r_rem  <= {1'b0, i_q_rdata[REC_W-2 -: VALUE_BITS]};
            r_quo  <= '0;
            r_step <= '0;
        end else if (do_step) begin
            r_rem  <= rem_ge ? (rem_in - {1'b0, q_peak}) : rem_in;
            r_quo  <= {r_quo[RATIO_FRAC_BITS-1:0], rem_ge};
            r_step <= r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_found_drop       <= q_found;
            o_drop_amount      <= q_drop;
            o_drop_ratio       <= q_found ? r_quo : '0;
            o_peak_value_out   <= q_peak;
            o_trough_value_out <= q_trough;
            o_peak_date_out    <= q_pdate;
            o_trough_date_out  <= q_tdate;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: sv/max_drawdown_tracker_unit.sv
// Max drawdown tracker: running peak and best drop, one sample transaction per cycle.
// Throughput: one sample per cycle; input stalls only while two finished streams wait.
// Result path: once the last sample of a stream is accepted, its record waits in the queue,
// then runs through the one-bit-per-cycle ratio divider (skipped with no drop) and is
// registered on the outputs, also waiting behind earlier results.
// Reset: synchronous, active low; clears tracking state, queue and output valid.
module max_drawdown_tracker_unit import mdt_pkg::*; #(
    parameter int unsigned VALUE_BITS      = MDT_VALUE_BITS,
    parameter int unsigned DATE_BITS       = MDT_DATE_BITS,
    parameter int unsigned RATIO_FRAC_BITS = MDT_RATIO_FRAC_BITS,
    parameter int unsigned INDEX_BITS      = MDT_INDEX_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [DATE_BITS-1:0]       i_date_stamp,
    input  logic [VALUE_BITS-1:0]      i_portfolio_value,
    input  logic                       i_last_item,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_found_drop,
    output logic [VALUE_BITS-1:0]      o_drop_amount,
    output logic [RATIO_FRAC_BITS:0]   o_drop_ratio,
    output logic [VALUE_BITS-1:0]      o_peak_value_out,
    output logic [VALUE_BITS-1:0]      o_trough_value_out,
    output logic [DATE_BITS-1:0]       o_peak_date_out,
    output logic [DATE_BITS-1:0]       o_trough_date_out
);

    localparam int unsigned REC_W = 1 + 3 * VALUE_BITS + 2 * DATE_BITS;

    t_q_status        q_status;
    logic             q_push;
    logic             q_pop;
    logic [REC_W-1:0] q_wdata;
    logic [REC_W-1:0] q_rdata;

    mdt_front #(
        .VALUE_BITS (VALUE_BITS),
        .DATE_BITS  (DATE_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_date_stamp      (i_date_stamp),
        .i_portfolio_value (i_portfolio_value),
        .i_last_item       (i_last_item),
        .i_q_status        (q_status),
        .o_q_push          (q_push),
        .o_q_wdata         (q_wdata)
    );

    mdt_queue #(
        .WIDTH (REC_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_wdata  (q_wdata),
        .i_pop    (q_pop),
        .o_rdata  (q_rdata),
        .o_status (q_status)
    );

    mdt_back #(
        .VALUE_BITS      (VALUE_BITS),
        .DATE_BITS       (DATE_BITS),
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_status         (q_status),
        .i_q_rdata          (q_rdata),
        .o_q_pop            (q_pop),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_found_drop       (o_found_drop),
        .o_drop_amount      (o_drop_amount),
        .o_drop_ratio       (o_drop_ratio),
        .o_peak_value_out   (o_peak_value_out),
        .o_trough_value_out (o_trough_value_out),
        .o_peak_date_out    (o_peak_date_out),
        .o_trough_date_out  (o_trough_date_out)
    );

endmodule

// File: sv/mdt_checker.sv
`include "assert_macros.svh"

module mdt_checker import mdt_pkg::*; #(
    parameter int unsigned VALUE_BITS      = MDT_VALUE_BITS,
    parameter int unsigned DATE_BITS       = MDT_DATE_BITS,
    parameter int unsigned RATIO_FRAC_BITS = MDT_RATIO_FRAC_BITS
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic                       o_found_drop,
    input logic [VALUE_BITS-1:0]      o_drop_amount,
    input logic [RATIO_FRAC_BITS:0]   o_drop_ratio,
    input logic [VALUE_BITS-1:0]      o_peak_value_out,
    input logic [VALUE_BITS-1:0]      o_trough_value_out,
    input logic [DATE_BITS-1:0]       o_peak_date_out,
    input logic [DATE_BITS-1:0]       o_trough_date_out
);

    localparam logic [RATIO_FRAC_BITS:0] RATIO_ONE = {1'b1, {RATIO_FRAC_BITS{1'b0}}};

    // A stalled result transaction holds.
    `ASSERT_CLK_RST(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_drop_amount) && $stable(o_drop_ratio)))

    // No drop: every other field reads zero.
    `ASSERT_CLK_RST(a_empty_zero, i_clk, i_rst_n, (o_out_valid && !o_found_drop) |-> (o_drop_amount == '0 && o_drop_ratio == '0 && o_peak_value_out == '0 && o_trough_value_out == '0 && o_peak_date_out == '0 && o_trough_date_out == '0))

    // A reported drop is a positive peak-to-trough difference.
    `ASSERT_CLK_RST(a_drop_diff, i_clk, i_rst_n, (o_out_valid && o_found_drop) |-> (o_peak_value_out > o_trough_value_out && o_drop_amount == o_peak_value_out - o_trough_value_out))

    // The ratio never exceeds one.
    `ASSERT_CLK_RST(a_ratio_max, i_clk, i_rst_n, o_out_valid |-> (o_drop_ratio <= RATIO_ONE))

endmodule

bind max_drawdown_tracker_unit mdt_checker #(
    .VALUE_BITS      (VALUE_BITS),
    .DATE_BITS       (DATE_BITS),
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
) u_mdt_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_found_drop       (o_found_drop),
    .o_drop_amount      (o_drop_amount),
    .o_drop_ratio       (o_drop_ratio),
    .o_peak_value_out   (o_peak_value_out),
    .o_trough_value_out (o_trough_value_out),
    .o_peak_date_out    (o_peak_date_out),
    .o_trough_date_out  (o_trough_date_out)
);
